// ===== rtl/bfsp_pkg.sv =====
package bfsp_pkg;

  localparam int VW  = 7;
  localparam int DW  = 24;
  localparam int WW  = 16;
  localparam int OPW = 2;

  localparam logic [OPW-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPW-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPW-1:0] OP_RUN   = 2'd2;

  // byte address of the vertex count register
  localparam logic REG_VCOUNT = 1'b0;
  localparam logic [VW-1:0] VCOUNT_RST = 7'd64;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  localparam logic signed [DW-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DW-1:0] DIST_MIN = 24'sh800000;

  typedef struct packed {
    logic [OPW-1:0]       op;
    logic [VW-1:0]        from_vertex;
    logic [VW-1:0]        to_vertex;
    logic signed [WW-1:0] edge_weight;
    logic [VW-1:0]        start_vertex;
  } bfsp_in_t;

  typedef struct packed {
    logic [VW-1:0]        vertex;
    logic                 reached;
    logic signed [DW-1:0] distance;
    logic                 last;
  } bfsp_out_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_CLEAR,
    CMD_RUN
  } bfsp_kind_t;

  // for a run, a carries the start vertex
  typedef struct packed {
    bfsp_kind_t           kind;
    logic [VW-1:0]        a;
    logic [VW-1:0]        b;
    logic signed [WW-1:0] w;
  } bfsp_cmd_t;

  typedef struct packed {
    logic      valid;
    bfsp_cmd_t cmd;
  } bfsp_head_t;

  typedef struct packed {
    logic [VW-1:0]        a;
    logic [VW-1:0]        b;
    logic signed [WW-1:0] w;
  } bfsp_edge_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_READ,
    ST_FWD,
    ST_REV,
    ST_EMIT
  } bfsp_state_t;

  // distance plus weight, clamped to the 24-bit signed range
  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] d,
                                                   input logic signed [WW-1:0] w);
    logic signed [DW:0] s;
    s = {d[DW-1], d} + {{(DW+1-WW){w[WW-1]}}, w};
    if (s[DW] != s[DW-1]) begin
      sat_add = s[DW] ? DIST_MIN : DIST_MAX;
    end else begin
      sat_add = s[DW-1:0];
    end
  endfunction

endpackage

// ===== rtl/bfsp_front.sv =====
module bfsp_front import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  bfsp_in_t   in_req,
  input  logic       pop,
  output bfsp_head_t head
);

  bfsp_cmd_t        q_mem [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]     cnt_r, cnt_nxt;
  logic             full;
  logic             push;
  logic             ends_ok;
  bfsp_cmd_t        cmd;

  assign full = (cnt_r == (QPW+1)'(QDEPTH));
  assign busy = full;

  // classify: drop loads with bad ends and unused ops
  always_comb begin
    ends_ok = (in_req.from_vertex != '0) && (in_req.from_vertex <= VW'(MAX_VERTICES)) &&
              (in_req.to_vertex != '0) && (in_req.to_vertex <= VW'(MAX_VERTICES));
    cmd.kind = CMD_LOAD;
    cmd.a    = in_req.from_vertex;
    cmd.b    = in_req.to_vertex;
    cmd.w    = in_req.edge_weight;
    push     = 1'b0;
    case (in_req.op)
      OP_LOAD: begin
        push = ends_ok;
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
        push     = 1'b1;
      end
      OP_RUN: begin
        cmd.kind = CMD_RUN;
        cmd.a    = in_req.start_vertex;
        push     = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
    push = push && start && !full;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPW+1)'(push) - (QPW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_mem[rd_ptr_r];

endmodule

// ===== rtl/bfsp_back.sv =====
module bfsp_back import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 512
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bfsp_head_t    head,
  output logic          pop,
  input  logic [VW-1:0] vcount,
  output logic          out_valid,
  output bfsp_out_t     out_res
);

  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);

  bfsp_edge_t           edge_mem [MAX_EDGES];
  logic signed [DW-1:0] dist_mem [MAX_VERTICES];

  bfsp_state_t          state_r, state_nxt;
  logic [EC_W-1:0]      etotal_r, etotal_nxt;
  logic [EC_W-1:0]      ecnt_r, ecnt_nxt;
  logic [VA_W-1:0]      pass_r, pass_nxt;
  logic [VW-1:0]        n_r, n_nxt;
  logic [VW-1:0]        emit_v_r, emit_v_nxt;
  logic                 emit_pend_r, emit_pend_nxt;
  logic                 emit_last_r, emit_last_nxt;
  logic [VW-1:0]        out_v_r, out_v_nxt;
  logic [MAX_VERTICES-1:0] valid_r, valid_nxt;

  bfsp_edge_t           edge_rd_r;
  logic signed [DW-1:0] da_r, da_nxt, db_r, db_nxt;
  logic                 va_r, va_nxt, vb_r, vb_nxt;

  logic                 edge_we, edge_re;
  logic                 rd_a_en, rd_b_en;
  logic [VA_W-1:0]      ra_addr, rb_addr;
  logic                 dw_en;
  logic [VA_W-1:0]      dw_addr;
  logic signed [DW-1:0] dw_data;

  logic [VW-1:0]        n_eff;
  logic [VW-1:0]        s_vtx;
  logic                 last_edge, last_pass, ends_in;
  logic signed [DW-1:0] cand_fwd, cand_rev;
  logic [VA_W-1:0]      ia, ib;

  always_comb begin
    if (vcount == '0) begin
      n_eff = VW'(1);
    end else if (vcount > VW'(MAX_VERTICES)) begin
      n_eff = VW'(MAX_VERTICES);
    end else begin
      n_eff = vcount;
    end
  end

  assign s_vtx     = head.cmd.a;
  assign ia        = VA_W'(edge_rd_r.a - VW'(1));
  assign ib        = VA_W'(edge_rd_r.b - VW'(1));
  assign ends_in   = (edge_rd_r.a <= n_r) && (edge_rd_r.b <= n_r);
  assign last_edge = ((ecnt_r + EC_W'(1)) == etotal_r);
  assign last_pass = ((VW'(pass_r) + VW'(1)) == (n_r - VW'(1)));
  assign cand_fwd  = sat_add(da_r, edge_rd_r.w);
  assign cand_rev  = sat_add(db_r, edge_rd_r.w);

  always_comb begin
    state_nxt     = state_r;
    etotal_nxt    = etotal_r;
    ecnt_nxt      = ecnt_r;
    pass_nxt      = pass_r;
    n_nxt         = n_r;
    emit_v_nxt    = emit_v_r;
    emit_pend_nxt = 1'b0;
    emit_last_nxt = emit_last_r;
    out_v_nxt     = out_v_r;
    valid_nxt     = valid_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    pop           = 1'b0;
    edge_we       = 1'b0;
    edge_re       = 1'b0;
    rd_a_en       = 1'b0;
    rd_b_en       = 1'b0;
    ra_addr       = ia;
    rb_addr       = ib;
    dw_en         = 1'b0;
    dw_addr       = ib;
    dw_data       = cand_fwd;

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.kind)
            CMD_LOAD: begin
              if (etotal_r != EC_W'(MAX_EDGES)) begin
                edge_we    = 1'b1;
                etotal_nxt = etotal_r + EC_W'(1);
              end
            end
            CMD_CLEAR: begin
              etotal_nxt = '0;
            end
            CMD_RUN: begin
              n_nxt     = n_eff;
              valid_nxt = '0;
              if (s_vtx != '0 && s_vtx <= n_eff) begin
                valid_nxt[VA_W'(s_vtx - VW'(1))] = 1'b1;
                dw_en   = 1'b1;
                dw_addr = VA_W'(s_vtx - VW'(1));
                dw_data = '0;
              end
              pass_nxt   = '0;
              ecnt_nxt   = '0;
              emit_v_nxt = VW'(1);
              if (n_eff == VW'(1) || etotal_r == '0) begin
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_FETCH;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        edge_re   = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (ends_in) begin
          rd_a_en   = 1'b1;
          rd_b_en   = 1'b1;
          va_nxt    = valid_r[ia];
          vb_nxt    = valid_r[ib];
          state_nxt = ST_FWD;
        end
      end
      ST_FWD: begin
        if (va_r && (!vb_r || cand_fwd < db_r)) begin
          dw_en          = 1'b1;
          dw_addr        = ib;
          dw_data        = cand_fwd;
          valid_nxt[ib]  = 1'b1;
          db_nxt         = cand_fwd;
          vb_nxt         = 1'b1;
          if (edge_rd_r.a == edge_rd_r.b) begin
            da_nxt = cand_fwd;
            va_nxt = 1'b1;
          end
        end
        state_nxt = ST_REV;
      end
      ST_REV: begin
        if (vb_r && (!va_r || cand_rev < da_r)) begin
          dw_en         = 1'b1;
          dw_addr       = ia;
          dw_data       = cand_rev;
          valid_nxt[ia] = 1'b1;
        end
      end
      ST_EMIT: begin
        rd_a_en       = 1'b1;
        ra_addr       = VA_W'(emit_v_r - VW'(1));
        va_nxt        = valid_r[VA_W'(emit_v_r - VW'(1))];
        emit_pend_nxt = 1'b1;
        out_v_nxt     = emit_v_r;
        emit_last_nxt = (emit_v_r == n_r);
        if (emit_v_r == n_r) begin
          state_nxt = ST_IDLE;
        end else begin
          emit_v_nxt = emit_v_r + VW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // advance to the next edge, the next pass or the result sweep
    if ((state_r == ST_REV) || (state_r == ST_READ && !ends_in)) begin
      if (!last_edge) begin
        ecnt_nxt  = ecnt_r + EC_W'(1);
        state_nxt = ST_FETCH;
      end else begin
        ecnt_nxt = '0;
        if (last_pass) begin
          state_nxt = ST_EMIT;
        end else begin
          pass_nxt  = pass_r + VA_W'(1);
          state_nxt = ST_FETCH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      etotal_r    <= '0;
      ecnt_r      <= '0;
      pass_r      <= '0;
      n_r         <= VW'(1);
      emit_v_r    <= VW'(1);
      emit_pend_r <= 1'b0;
      emit_last_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      etotal_r    <= etotal_nxt;
      ecnt_r      <= ecnt_nxt;
      pass_r      <= pass_nxt;
      n_r         <= n_nxt;
      emit_v_r    <= emit_v_nxt;
      emit_pend_r <= emit_pend_nxt;
      emit_last_r <= emit_last_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_v_r <= out_v_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[etotal_r[EA_W-1:0]] <= '{a: head.cmd.a, b: head.cmd.b, w: head.cmd.w};
    end
    if (edge_re) begin
      edge_rd_r <= edge_mem[ecnt_r[EA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dw_en) begin
      dist_mem[dw_addr] <= dw_data;
    end
    if (rd_a_en) begin
      da_r <= dist_mem[ra_addr];
    end else begin
      da_r <= da_nxt;
    end
    if (rd_b_en) begin
      db_r <= dist_mem[rb_addr];
    end else begin
      db_r <= db_nxt;
    end
  end

  assign out_valid        = emit_pend_r;
  assign out_res.vertex   = out_v_r;
  assign out_res.reached  = va_r;
  assign out_res.distance = va_r ? da_r : '0;
  assign out_res.last     = emit_last_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    etotal_r <= EC_W'(MAX_EDGES))
    else $error("edge count above store depth");

  a_strobe_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    emit_pend_r |-> $past(state_r == ST_EMIT))
    else $error("result strobe outside the result sweep");

  a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (ecnt_r < etotal_r))
    else $error("edge index beyond stored edges");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_pend_r && emit_last_r) |=> !emit_pend_r)
    else $error("result after the last vertex");

endmodule

// ===== rtl/bellman_ford_shortest_path_core.sv =====
// Channel   Handshake                   Payload
// ------    ---------------------------  --------------------------------------
// input     start / busy                 in_req  (op, ends, weight, start vertex)
// result    out_valid strobe, no stall   out_res (vertex, reached, distance, last)
// config    psel/penable/pwrite, pready  vertex_count at byte address 0
//
// A request is taken when start is high and busy is low; up to four requests
// queue ahead of the executing back end, and busy rises only when that queue
// is full. A run sets up the start vertex, then makes (n-1) passes over the
// stored edges: fetch, read both distances, relax forward, relax reverse for
// an edge in range, only fetch and read for a skipped edge; then one result
// per cycle for each of the n vertices. The single distance memory write port
// and its registered reads set the per-edge steps. Reset (rst_n low,
// synchronous) empties the queue and edge store and restores vertex_count to
// 64. Results cannot be held off by the receiver.
module bellman_ford_shortest_path_core import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  bfsp_in_t    in_req,
  // result channel
  output logic        out_valid,
  output bfsp_out_t   out_res,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [VW-1:0] vcount_r;
  bfsp_head_t    head;
  logic          pop;

  // Hold the vertex count; the user must write it only while the core is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_VCOUNT) begin
      vcount_r <= pwdata[VW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_VCOUNT) ? {{(32-VW){1'b0}}, vcount_r} : '0;

  // Front end: classify requests, drop malformed loads and unused ops, queue.
  bfsp_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_req (in_req),
    .pop    (pop),
    .head   (head)
  );

  // Back end: edge store, distance store and the relaxation sequencer.
  bfsp_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .vcount    (vcount_r),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import bfsp_pkg::*;

  localparam int MAXV            = 64;
  localparam int MAXE            = 512;
  // Idle cycles allowed after the last result before the config port is touched,
  // so that queued load and clear requests have drained from the back end.
  localparam int DRAIN           = 32;
  localparam int RANDOM_REQUESTS = 130;
  localparam int NO_WRITE        = -1;

  // op 3 carries no meaning and the block drops it
  localparam logic [OPW-1:0] OP_SPARE = 2'd3;

  // How a directed row is checked: by the predictor, by no result at all, or
  // by the typed-in answer that every vertex is left unreached.
  typedef enum {CHK_MODEL, CHK_SILENT, CHK_UNREACHED} row_check_t;

  typedef struct {
    int         vc;
    bfsp_in_t   req;
    row_check_t chk;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  bfsp_in_t    in_req;
  logic        out_valid;
  bfsp_out_t   out_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bellman_ford_shortest_path_core #(
    .MAX_VERTICES (MAXV),
    .MAX_EDGES    (MAXE)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow of the graph held by the block: edge list in load order, the
  // vertex count register and the per-vertex distances of the latest run.
  logic [VW-1:0]        edge_a [MAXE];
  logic [VW-1:0]        edge_b [MAXE];
  logic signed [WW-1:0] edge_w [MAXE];
  int                   edge_cnt;
  logic [VW-1:0]        vcount;
  bit                   hit      [MAXV+1];
  logic signed [DW-1:0] path_len [MAXV+1];

  // Distance reports still owed by the block, oldest first.
  bfsp_out_t expected_results[$];
  stim_row_t directed[$];

  int mismatches;
  int results_checked;
  int requests_sent;
  int runs_sent;
  int cfg_writes;
  bit burst;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #500_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic signed [DW-1:0] clamp_sum(input logic signed [DW-1:0] d,
                                                     input logic signed [WW-1:0] w);
    int s;
    s = int'(d) + int'(w);
    if (s > int'(DIST_MAX)) return DIST_MAX;
    if (s < int'(DIST_MIN)) return DIST_MIN;
    return DW'(s);
  endfunction

  // Register values of 0 and above MAXV are folded into range.
  function automatic int active_count();
    if (vcount == '0) return 1;
    if (int'(vcount) > MAXV) return MAXV;
    return int'(vcount);
  endfunction

  // Relax one direction of an edge; never relax out of an unreached vertex.
  function automatic void relax_edge(input int f, input int t, input logic signed [WW-1:0] w);
    logic signed [DW-1:0] cand;
    if (!hit[f]) return;
    cand = clamp_sum(path_len[f], w);
    if (!hit[t] || cand < path_len[t]) begin
      hit[t]      = 1'b1;
      path_len[t] = cand;
    end
  endfunction

  function automatic bfsp_in_t make_req(input logic [OPW-1:0] op, input int a, input int b,
                                        input int w, input int s);
    bfsp_in_t r;
    r.op           = op;
    r.from_vertex  = VW'(a);
    r.to_vertex    = VW'(b);
    r.edge_weight  = WW'(w);
    r.start_vertex = VW'(s);
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input int vc, input logic [OPW-1:0] op, input int a,
                                  input int b, input int w, input int s,
                                  input row_check_t chk);
    stim_row_t r;
    r.vc  = vc;
    r.req = make_req(op, a, b, w, s);
    r.chk = chk;
    directed = {directed, r};
  endfunction

  // Append one report to the owed list.
  function automatic void owe_result(input bfsp_out_t r);
    expected_results = {expected_results, r};
  endfunction

  // Apply one accepted request to the shadow graph; for a run, optionally
  // queue one distance report per active vertex.
  task automatic predict_request(input bfsp_in_t req, input bit keep);
    int        n;
    int        s;
    int        a;
    int        b;
    bfsp_out_t r;
    case (req.op)
      OP_LOAD: begin
        a = int'(req.from_vertex);
        b = int'(req.to_vertex);
        if (a >= 1 && a <= MAXV && b >= 1 && b <= MAXV && edge_cnt < MAXE) begin
          edge_a[edge_cnt] = req.from_vertex;
          edge_b[edge_cnt] = req.to_vertex;
          edge_w[edge_cnt] = req.edge_weight;
          edge_cnt++;
        end
      end
      OP_CLEAR: edge_cnt = 0;
      OP_RUN: begin
        n = active_count();
        s = int'(req.start_vertex);
        for (int v = 0; v <= MAXV; v++) begin
          hit[v]      = 1'b0;
          path_len[v] = '0;
        end
        if (s >= 1 && s <= n) hit[s] = 1'b1;
        for (int p = 0; p + 1 < n; p++) begin
          for (int e = 0; e < edge_cnt; e++) begin
            a = int'(edge_a[e]);
            b = int'(edge_b[e]);
            // skip edges that reach beyond the active vertex count
            if (a <= n && b <= n) begin
              relax_edge(a, b, edge_w[e]);
              relax_edge(b, a, edge_w[e]);
            end
          end
        end
        if (keep) begin
          for (int v = 1; v <= n; v++) begin
            r.vertex   = VW'(v);
            r.reached  = hit[v];
            r.distance = hit[v] ? path_len[v] : '0;
            r.last     = (v == n);
            owe_result(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t  %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Present a request after a random gap and hold it until busy is low at an
  // edge. Leave start high on return, so the next request may follow directly.
  task automatic send_request(input bfsp_in_t req);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  task automatic issue(input bfsp_in_t req, input row_check_t chk);
    bfsp_out_t r;
    int        n;
    send_request(req);
    if (req.op == OP_RUN) runs_sent++;
    predict_request(req, chk == CHK_MODEL);
    if (chk == CHK_UNREACHED) begin
      n = active_count();
      for (int v = 1; v <= n; v++) begin
        r.vertex   = VW'(v);
        r.reached  = 1'b0;
        r.distance = '0;
        r.last     = (v == n);
        owe_result(r);
      end
    end
  endtask

  // Drop start, wait for every owed report, then let the back end drain.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write the vertex count register, then read it back over the same port.
  task automatic write_vertex_count(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_VCOUNT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    vcount = value[VW-1:0];
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata[VW-1:0] !== vcount) report_mismatch("vertex_count readback",
                                                   int'(vcount), int'(prdata[VW-1:0]));
  endtask

  // Result monitor: every strobe must match the oldest owed report.
  always @(posedge clk) begin
    bfsp_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t  unexpected result: vertex %0d reached %0b distance %0d last %0b",
                 $time, out_res.vertex, out_res.reached, out_res.distance, out_res.last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_res.vertex !== want.vertex)
          report_mismatch("vertex", int'(want.vertex), int'(out_res.vertex));
        if (out_res.reached !== want.reached)
          report_mismatch("reached", int'(want.reached), int'(out_res.reached));
        if (out_res.distance !== want.distance)
          report_mismatch("distance", int'(want.distance), int'(out_res.distance));
        if (out_res.last !== want.last)
          report_mismatch("last", int'(want.last), int'(out_res.last));
      end
    end
  end

  initial begin : main
    int counted;
    int pick;
    int vc;
    int n;
    int k;
    int a;
    int b;
    int w;
    int s;
    int runs;

    // Hold every input at a known value and keep reset low.
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_req  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_VCOUNT;
    pwdata  <= '0;
    vcount   = VCOUNT_RST;
    edge_cnt = 0;
    burst    = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    requests_sent   = 0;
    runs_sent       = 0;
    cfg_writes      = 0;
    counted         = 0;

    // Directed table: vertex count to write first, request, how to check it.
    // Straight out of reset no start vertex means 64 unreached reports.
    add_row(NO_WRITE, OP_RUN,     0,   0,      0,  0, CHK_UNREACHED);
    add_row(NO_WRITE, OP_RUN,   127, 127,     -1,  1, CHK_MODEL);
    add_row(NO_WRITE, OP_SPARE,   1,   2,      5,  1, CHK_SILENT);
    // Four parallel negative edges: a negative cycle driven into saturation.
    add_row(NO_WRITE, OP_LOAD,    1,   2, -32768,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    1,   2, -32768,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    2,   1, -32768,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    1,   2, -32768,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_RUN,     0,   0,      0,  1, CHK_MODEL);
    add_row(NO_WRITE, OP_CLEAR,   0,   0,      0,  0, CHK_SILENT);
    // Loads with an end of 0 or above the vertex limit are dropped.
    add_row(NO_WRITE, OP_LOAD,    0,   5,      5,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,   65,   3,      9,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    3, 127,      9,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    1,   2,  32767,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    2,   3,     -1,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    3,   4,    100,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    5,   6,      7,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,    4,   8,      3,  0, CHK_SILENT);
    add_row(NO_WRITE, OP_LOAD,   64,   1,    -20,  0, CHK_SILENT);
    // Edges beyond four vertices are skipped; a start above the count reaches nothing.
    add_row(4,        OP_RUN,     0,   0,      0,  1, CHK_MODEL);
    add_row(NO_WRITE, OP_RUN,     0,   0,      0,  5, CHK_UNREACHED);
    add_row(0,        OP_RUN,     0,   0,      0,  1, CHK_MODEL);
    add_row(127,      OP_RUN,     0,   0,      0, 64, CHK_MODEL);
    add_row(8,        OP_RUN,     0,   0,      0,  6, CHK_MODEL);
    add_row(NO_WRITE, OP_CLEAR,   0,   0,      0,  0, CHK_SILENT);
    add_row(1,        OP_RUN,     0,   0,      0,  1, CHK_MODEL);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].vc != NO_WRITE) begin
        wait_idle();
        write_vertex_count(directed[i].vc);
      end
      issue(directed[i].req, directed[i].chk);
    end

    // Random part: build a small graph, run it once or twice, repeat.
    while (counted < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 15);
      case (pick)
        0:       vc = 0;
        1:       vc = 1;
        2:       vc = MAXV;
        3:       vc = 127;
        4:       vc = $urandom_range(11, MAXV);
        default: vc = $urandom_range(2, 10);
      endcase
      wait_idle();
      write_vertex_count(($urandom() & ~32'h7F) | 32'(vc));
      n     = active_count();
      burst = ($urandom_range(0, 3) == 0);

      if (edge_cnt > 40 || $urandom_range(0, 3) != 0) begin
        issue(make_req(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 65535), $urandom_range(0, 127)), CHK_MODEL);
        counted++;
      end

      k = $urandom_range(0, 12);
      for (int j = 0; j < k; j++) begin
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        pick = $urandom_range(0, 9);
        // mostly well-formed edges, now and then a broken or out-of-range end
        if (pick == 0) a = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
        if (pick == 1) b = $urandom_range(1, MAXV);
        if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 65535);
        else w = $urandom_range(0, 80) - 20;
        issue(make_req(OP_LOAD, a, b, w, $urandom_range(0, 127)), CHK_MODEL);
        if (a >= 1 && a <= MAXV && b >= 1 && b <= MAXV) counted++;
        if ($urandom_range(0, 15) == 0)
          issue(make_req(OP_SPARE, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 65535), $urandom_range(0, 127)), CHK_MODEL);
      end

      runs = $urandom_range(1, 2);
      for (int j = 0; j < runs; j++) begin
        s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, n);
        issue(make_req(OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 65535), s), CHK_MODEL);
        counted++;
      end
    end

    burst = 1'b0;
    wait_idle();
    $display("covered %0d requests, %0d of them runs, under %0d vertex count writes",
             requests_sent, runs_sent, cfg_writes);
    $display("compared %0d distance reports field by field", results_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
